// ----- hdl/pwm_icm_pkg.sv -----
// ----------------------------------------------------------------------------
// pwm_icm_pkg
// shared widths, constants and divider control types for the pwm capture
// measurement block
// ----------------------------------------------------------------------------
package pwm_icm_pkg;

  localparam int unsigned TICK_W     = 32;
  localparam int unsigned CLK_HZ_W   = 30;
  localparam int unsigned PRESCALE_W = 17;
  localparam int unsigned FREQ_W     = 38;
  localparam int unsigned DUTY_W     = 15;

  localparam int unsigned DIV_DEN_W  = PRESCALE_W + TICK_W;
  localparam int unsigned DIV_Q_W    = FREQ_W;
  localparam int unsigned DIV_CNT_W  = 6;
  localparam int unsigned DUTY_PROD_W = TICK_W + DUTY_W;

  localparam logic [DIV_CNT_W-1:0] FREQ_STEPS = DIV_CNT_W'(FREQ_W);
  localparam logic [DIV_CNT_W-1:0] DUTY_STEPS = DIV_CNT_W'(DUTY_W);

  localparam logic [DUTY_W-1:0] DUTY_FULL = 15'd25600;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNTER_TOP  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMER_CLK_HZ = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESCALE     = 2'd2;

  typedef struct packed {
    logic                 start;
    logic [DIV_CNT_W-1:0] steps;
    logic [DIV_DEN_W-1:0] den;
    logic [DIV_DEN_W-1:0] rem;
    logic [DIV_Q_W-1:0]   dq;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [DIV_Q_W-1:0] quo;
  } div_rsp_t;

endpackage

// ----- hdl/pwm_icm_div.sv -----
// ----------------------------------------------------------------------------
// pwm_icm_div
// restoring divider, one quotient bit per cycle; the dividend bits are
// shifted out of the top of the quotient register as quotient bits enter
// ----------------------------------------------------------------------------
module pwm_icm_div
  import pwm_icm_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [DIV_DEN_W-1:0] den_q, den_d;
  logic [DIV_DEN_W-1:0] rem_q, rem_d;
  logic [DIV_Q_W-1:0]   dq_q, dq_d;

  logic [DIV_DEN_W:0] trial;
  logic [DIV_DEN_W:0] diff;
  logic               fits;

  assign trial = {rem_q, dq_q[DIV_Q_W-1]};
  assign diff  = trial - {1'b0, den_q};
  assign fits  = trial >= {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    den_d  = den_q;
    rem_d  = rem_q;
    dq_d   = dq_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = req_i.steps;
      den_d  = req_i.den;
      rem_d  = req_i.rem;
      dq_d   = req_i.dq;
    end else if (busy_q) begin
      rem_d = fits ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
      dq_d  = {dq_q[DIV_Q_W-2:0], fits};
      cnt_d = cnt_q - DIV_CNT_W'(1);
      if (cnt_q == DIV_CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    den_q <= den_d;
    rem_q <= rem_d;
    dq_q  <= dq_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = dq_q;

endmodule

// ----- hdl/pwm_input_capture_measure_top.sv -----
// ----------------------------------------------------------------------------
// pwm_input_capture_measure_top
// pwm input capture: period, pulse width, frequency and duty from edge
// captures, with a shared iterative divider under a small sequencer
// ----------------------------------------------------------------------------
//   channel | direction | handshake             | payload
//   in      | sink      | in_valid_i/in_ready_o | capture_value_i, edge_level_i
//   out     | source    | out_valid_o/out_ready_i | period, pulse, frequency, duty
//   cfg     | sink      | cfg_we_i, no stall    | cfg_idx_i, cfg_data_i
//
// one word at a time: acceptance, a multiply state, 38 divider steps for
// frequency and 15 for duty, plus the start and done sequencing states;
// a zero period skips the divider, a pulse not shorter than the period skips
// the duty division.
// reset is asynchronous and active low; no clearing pass is needed.
// the result register frees the sequencer unless a previous word is still held
// ----------------------------------------------------------------------------
module pwm_input_capture_measure_top
  import pwm_icm_pkg::*;
#(
  parameter int unsigned COUNTER_WIDTH = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [TICK_W-1:0]     capture_value_i,
  input  logic                  edge_level_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [TICK_W-1:0]     period_ticks_o,
  output logic [TICK_W-1:0]     pulse_ticks_o,
  output logic [FREQ_W-1:0]     frequency_q8_o,
  output logic [DUTY_W-1:0]     duty_q8_o
);

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_MUL     = 3'd1;
  localparam logic [2:0] ST_FSTART  = 3'd2;
  localparam logic [2:0] ST_FWAIT   = 3'd3;
  localparam logic [2:0] ST_DSTART  = 3'd4;
  localparam logic [2:0] ST_DWAIT   = 3'd5;
  localparam logic [2:0] ST_DONE    = 3'd6;

  logic [2:0] state_q, state_d;

  // configuration
  logic [COUNTER_WIDTH-1:0] counter_top_q;
  logic [CLK_HZ_W-1:0]      clk_hz_q;
  logic [PRESCALE_W-1:0]    prescale_q;

  // measurement state
  logic [COUNTER_WIDTH-1:0] last_rise_q;
  logic [TICK_W-1:0]        period_q;
  logic [TICK_W-1:0]        pulse_q;

  // working registers
  logic [DIV_DEN_W-1:0]   den_q;
  logic [FREQ_W-1:0]      num_q;
  logic [DUTY_PROD_W-1:0] duty_prod_q;
  logic [FREQ_W-1:0]      freq_q;
  logic [DUTY_W-1:0]      duty_q;

  logic                   out_valid_q;
  logic [TICK_W-1:0]      out_period_q, out_pulse_q;
  logic [FREQ_W-1:0]      out_freq_q;
  logic [DUTY_W-1:0]      out_duty_q;

  logic                     accept;
  logic [COUNTER_WIDTH-1:0] cap;
  logic [TICK_W-1:0]        cap_w, last_w, top_w, edge_dist;
  logic [PRESCALE_W-1:0]    prescale_eff;
  logic                     out_load;
  logic                     duty_sat;

  div_req_t div_req;
  div_rsp_t div_rsp;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  assign cap       = capture_value_i[COUNTER_WIDTH-1:0];
  assign cap_w     = TICK_W'(cap);
  assign last_w    = TICK_W'(last_rise_q);
  assign top_w     = TICK_W'(counter_top_q);
  assign edge_dist = (cap >= last_rise_q) ? (cap_w - last_w)
                                          : (cap_w + top_w - last_w + TICK_W'(1));

  assign prescale_eff = (prescale_q == '0) ? PRESCALE_W'(1) : prescale_q;
  assign duty_sat     = (pulse_q >= period_q);
  assign out_load     = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);

  pwm_icm_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    div_req       = '0;
    div_req.start = 1'b0;
    unique case (state_q)
      ST_FSTART: begin
        div_req.start = 1'b1;
        div_req.steps = FREQ_STEPS;
        div_req.den   = den_q;
        div_req.rem   = '0;
        div_req.dq    = num_q;
      end
      ST_DSTART: begin
        div_req.start = 1'b1;
        div_req.steps = DUTY_STEPS;
        div_req.den   = DIV_DEN_W'(period_q);
        div_req.rem   = DIV_DEN_W'(duty_prod_q[DUTY_PROD_W-1:DUTY_W]);
        div_req.dq    = {duty_prod_q[DUTY_W-1:0], (DIV_Q_W - DUTY_W)'(0)};
      end
      default: begin
        div_req.start = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (accept) state_d = ST_MUL;
      ST_MUL:    state_d = (period_q == '0) ? ST_DONE : ST_FSTART;
      ST_FSTART: state_d = ST_FWAIT;
      ST_FWAIT:  if (div_rsp.done) state_d = duty_sat ? ST_DONE : ST_DSTART;
      ST_DSTART: state_d = ST_DWAIT;
      ST_DWAIT:  if (div_rsp.done) state_d = ST_DONE;
      ST_DONE:   if (out_load) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      counter_top_q <= COUNTER_WIDTH'(32'd65535);
      clk_hz_q      <= CLK_HZ_W'(170000000);
      prescale_q    <= PRESCALE_W'(1);
      last_rise_q   <= '0;
      period_q      <= '0;
      pulse_q       <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_COUNTER_TOP:  counter_top_q <= cfg_data_i[COUNTER_WIDTH-1:0];
          CFG_TIMER_CLK_HZ: clk_hz_q      <= cfg_data_i[CLK_HZ_W-1:0];
          CFG_PRESCALE:     prescale_q    <= cfg_data_i[PRESCALE_W-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        if (edge_level_i) begin
          if (last_rise_q != '0) period_q <= edge_dist;
          last_rise_q <= cap;
        end else if (last_rise_q != '0) begin
          pulse_q <= edge_dist;
        end
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_MUL) begin
      den_q       <= DIV_DEN_W'(prescale_eff) * DIV_DEN_W'(period_q);
      num_q       <= {clk_hz_q, 8'd0};
      duty_prod_q <= DUTY_PROD_W'(pulse_q) * DUTY_PROD_W'(DUTY_FULL);
      freq_q      <= '0;
      duty_q      <= '0;
    end
    if (state_q == ST_FWAIT && div_rsp.done) begin
      freq_q <= div_rsp.quo;
      if (duty_sat) duty_q <= DUTY_FULL;
    end
    if (state_q == ST_DWAIT && div_rsp.done) begin
      duty_q <= div_rsp.quo[DUTY_W-1:0];
    end
    if (out_load) begin
      out_period_q <= period_q;
      out_pulse_q  <= pulse_q;
      out_freq_q   <= freq_q;
      out_duty_q   <= duty_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign period_ticks_o = out_period_q;
  assign pulse_ticks_o  = out_pulse_q;
  assign frequency_q8_o = out_freq_q;
  assign duty_q8_o      = out_duty_q;

endmodule
